// File: rtl/uvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UV-sphere vertex generator package
// Shared widths, constants, beat types and rounding helpers.
// ----------------------------------------------------------------------------
package uvs_pkg;

   localparam int IdxW        = 11;
   localparam int RadW        = 16;
   localparam int RecipW      = 33;
   localparam int ProdW       = IdxW + RecipW;
   localparam int PosW        = 17;
   localparam int VecW        = 16;
   localparam int TexW        = 17;
   localparam int MaxCount    = 1024;
   localparam int CordicSteps = 16;
   localparam int AtanLen     = 24;

   localparam logic [1:0] RegRadius = 2'd0;
   localparam logic [1:0] RegSlices = 2'd1;
   localparam logic [1:0] RegStacks = 2'd2;

   localparam logic [RadW-1:0]   RadiusReset = 16'd256;
   localparam logic [IdxW-1:0]   CountReset  = 11'd20;
   localparam logic [RecipW-1:0] RecipReset  = 33'd214748365;

   localparam logic signed [31:0] CordicGain = 32'sd652032874;
   localparam logic [30:0]        HalfPiQ30  = 31'd1686629713;
   localparam logic [TexW-1:0]    TexOne     = 17'd65536;

   localparam logic signed [31:0] AtanTable [AtanLen] = '{
      32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159,
      32'sd67021687, 32'sd33543516, 32'sd16775851, 32'sd8388437,
      32'sd4194283, 32'sd2097149, 32'sd1048576, 32'sd524288,
      32'sd262144, 32'sd131072, 32'sd65536, 32'sd32768,
      32'sd16384, 32'sd8192, 32'sd4096, 32'sd2048,
      32'sd1024, 32'sd512, 32'sd256, 32'sd128
   };

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } rot_type;

   typedef struct packed {
      rot_type phi;
      rot_type theta;
   } cordic_type;

   typedef struct packed {
      logic            err;
      logic            pole_top;
      logic            pole_bot;
      logic [1:0]      quad_p;
      logic [1:0]      quad_t;
      logic [TexW-1:0] tex_u;
      logic [TexW-1:0] tex_v;
   } side_type;

   typedef struct packed {
      logic            index_error;
      logic [TexW-1:0] tex_v;
      logic [TexW-1:0] tex_u;
      logic [VecW-1:0] tangent_z;
      logic [VecW-1:0] tangent_y;
      logic [VecW-1:0] tangent_x;
      logic [VecW-1:0] normal_z;
      logic [VecW-1:0] normal_y;
      logic [VecW-1:0] normal_x;
      logic [PosW-1:0] pos_z;
      logic [PosW-1:0] pos_y;
      logic [PosW-1:0] pos_x;
   } res_type;

   function automatic logic [VecW-1:0] sat_q14(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = (v + 34'sd32768) >>> 16;
      if (t > 34'sd16384) begin
         return 16'sd16384;
      end else if (t < -34'sd16384) begin
         return -16'sd16384;
      end
      return t[VecW-1:0];
   endfunction

   function automatic logic [PosW-1:0] sat_pos(input logic signed [50:0] p);
      logic signed [50:0] t;
      t = (p + 51'sd536870912) >>> 30;
      if (t > 51'sd65535) begin
         return 17'sd65535;
      end else if (t < -51'sd65535) begin
         return -17'sd65535;
      end
      return t[PosW-1:0];
   endfunction

endpackage
`default_nettype wire

// File: rtl/uvs_recip_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Reciprocal divider
// Restoring division of (2^32 + d/2) by d, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module uvs_recip_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [uvs_pkg::IdxW-1:0]   divisor,
   output logic                            busy,
   output logic [uvs_pkg::RecipW-1:0]      quotient
);
   import uvs_pkg::*;

   localparam int CntW = $clog2(RecipW + 1);

   logic [CntW-1:0]   cnt_ff;
   logic [IdxW-1:0]   rem_ff;
   logic [RecipW-1:0] num_ff;
   logic [RecipW-1:0] quo_ff;
   logic [IdxW:0]     trial;
   logic              ge;

   always_comb begin
      trial = {rem_ff, num_ff[RecipW-1]};
      ge    = trial >= {1'b0, divisor};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         quo_ff <= RecipReset;
      end else if (start) begin
         cnt_ff <= CntW'(RecipW);
         rem_ff <= '0;
         num_ff <= {1'b1, 32'd0} + RecipW'(divisor >> 1);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= ge ? IdxW'(trial - {1'b0, divisor}) : trial[IdxW-1:0];
         num_ff <= {num_ff[RecipW-2:0], 1'b0};
         quo_ff <= {quo_ff[RecipW-2:0], ge};
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// File: rtl/uvs_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation step for the polar and azimuth angles, with its own beat slot.
// ----------------------------------------------------------------------------
module uvs_cordic_cell #(
   parameter int Step = 0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   up_valid,
   output logic                        up_ready,
   input  wire uvs_pkg::cordic_type    up_data,
   input  wire uvs_pkg::side_type      up_side,
   output logic                        down_valid,
   input  wire logic                   down_ready,
   output uvs_pkg::cordic_type         down_data,
   output uvs_pkg::side_type           down_side
);
   import uvs_pkg::*;

   logic       valid_ff;
   cordic_type data_ff, data_in;
   side_type   side_ff;

   function automatic rot_type rotate(input rot_type r);
      rot_type o;
      logic signed [31:0] dx, dy;
      dx = r.y >>> Step;
      dy = r.x >>> Step;
      if (!r.z[31]) begin
         o.x = r.x - dx;
         o.y = r.y + dy;
         o.z = r.z - AtanTable[Step];
      end else begin
         o.x = r.x + dx;
         o.y = r.y - dy;
         o.z = r.z + AtanTable[Step];
      end
      return o;
   endfunction

   always_comb begin
      up_ready        = !valid_ff || down_ready;
      data_in.phi     = rotate(up_data.phi);
      data_in.theta   = rotate(up_data.theta);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         data_ff <= data_in;
         side_ff <= up_side;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;
   assign down_side  = side_ff;

endmodule
`default_nettype wire

// File: rtl/uvs_post.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex post-processing
// Quadrant restore, products, radius scaling, rounding, pole and index error handling.
// ----------------------------------------------------------------------------
module uvs_post (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [uvs_pkg::RadW-1:0] radius,
   input  wire logic                     up_valid,
   output logic                          up_ready,
   input  wire uvs_pkg::cordic_type      up_data,
   input  wire uvs_pkg::side_type        up_side,
   output logic                          down_valid,
   input  wire logic                     down_ready,
   output uvs_pkg::res_type              down_data
);
   import uvs_pkg::*;

   localparam int Stages = 5;

   logic [Stages-1:0] valid_ff;
   logic [Stages:0]   rdy;
   side_type          side_ff [Stages-1];

   logic signed [31:0] sp_ff, cp_ff, st_ff, ct_ff;
   logic signed [31:0] sp_in, cp_in, st_in, ct_in;
   logic signed [63:0] mx_ff, mz_ff;
   logic signed [31:0] cp1_ff, st1_ff, ct1_ff;
   logic signed [32:0] qx_ff, qz_ff, qx_in, qz_in;
   logic signed [31:0] cp2_ff, st2_ff, ct2_ff;
   logic signed [50:0] px_ff, py_ff, pz_ff;
   logic [VecW-1:0]    nx_ff, ny_ff, nz_ff, tx_ff, tz_ff;
   res_type            res_ff, res_in;
   logic signed [16:0] rad_s;
   logic signed [63:0] rx_sum, rz_sum;

   always_comb begin
      rdy[Stages] = down_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end
   assign up_ready = rdy[0];

   always_comb begin
      case (up_side.quad_p)
         2'd0: begin cp_in = up_data.phi.x;  sp_in = up_data.phi.y;  end
         2'd1: begin cp_in = -up_data.phi.y; sp_in = up_data.phi.x;  end
         2'd2: begin cp_in = -up_data.phi.x; sp_in = -up_data.phi.y; end
         default: begin cp_in = up_data.phi.y; sp_in = -up_data.phi.x; end
      endcase
      case (up_side.quad_t)
         2'd0: begin ct_in = up_data.theta.x;  st_in = up_data.theta.y;  end
         2'd1: begin ct_in = -up_data.theta.y; st_in = up_data.theta.x;  end
         2'd2: begin ct_in = -up_data.theta.x; st_in = -up_data.theta.y; end
         default: begin ct_in = up_data.theta.y; st_in = -up_data.theta.x; end
      endcase
   end

   always_comb begin
      rx_sum = mx_ff + 64'sd536870912;
      rz_sum = mz_ff + 64'sd536870912;
      qx_in  = 33'(rx_sum >>> 30);
      qz_in  = 33'(rz_sum >>> 30);
      rad_s  = signed'({1'b0, radius});
   end

   always_comb begin
      res_in = '0;
      if (side_ff[3].err) begin
         res_in.index_error = 1'b1;
      end else if (side_ff[3].pole_top || side_ff[3].pole_bot) begin
         res_in.pos_y     = side_ff[3].pole_top ? PosW'({1'b0, radius})
                                                : PosW'(-rad_s);
         res_in.normal_y  = side_ff[3].pole_top ? 16'sd16384 : -16'sd16384;
         res_in.tangent_x = 16'sd16384;
      end else begin
         res_in.pos_x     = sat_pos(px_ff);
         res_in.pos_y     = sat_pos(py_ff);
         res_in.pos_z     = sat_pos(pz_ff);
         res_in.normal_x  = nx_ff;
         res_in.normal_y  = ny_ff;
         res_in.normal_z  = nz_ff;
         res_in.tangent_x = tx_ff;
         res_in.tangent_z = tz_ff;
         res_in.tex_u     = side_ff[3].tex_u;
         res_in.tex_v     = side_ff[3].tex_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (rdy[k]) begin
               valid_ff[k] <= (k == 0) ? up_valid : valid_ff[k-1];
            end
         end
      end
      if (rdy[0] && up_valid) begin
         sp_ff      <= sp_in;
         cp_ff      <= cp_in;
         st_ff      <= st_in;
         ct_ff      <= ct_in;
         side_ff[0] <= up_side;
      end
      if (rdy[1] && valid_ff[0]) begin
         mx_ff      <= sp_ff * ct_ff;
         mz_ff      <= sp_ff * st_ff;
         cp1_ff     <= cp_ff;
         st1_ff     <= st_ff;
         ct1_ff     <= ct_ff;
         side_ff[1] <= side_ff[0];
      end
      if (rdy[2] && valid_ff[1]) begin
         qx_ff      <= qx_in;
         qz_ff      <= qz_in;
         cp2_ff     <= cp1_ff;
         st2_ff     <= st1_ff;
         ct2_ff     <= ct1_ff;
         side_ff[2] <= side_ff[1];
      end
      if (rdy[3] && valid_ff[2]) begin
         px_ff      <= 51'(rad_s) * 51'(qx_ff);
         py_ff      <= 51'(rad_s) * 51'(cp2_ff);
         pz_ff      <= 51'(rad_s) * 51'(qz_ff);
         nx_ff      <= sat_q14(34'(qx_ff));
         ny_ff      <= sat_q14(34'(cp2_ff));
         nz_ff      <= sat_q14(34'(qz_ff));
         tx_ff      <= sat_q14(-34'(st2_ff));
         tz_ff      <= sat_q14(34'(ct2_ff));
         side_ff[3] <= side_ff[2];
      end
      if (rdy[4] && valid_ff[3]) begin
         res_ff     <= res_in;
      end
   end

   assign down_valid = valid_ff[Stages-1];
   assign down_data  = res_ff;

endmodule
`default_nettype wire

// File: rtl/uv_sphere_vertex_generator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// UV-sphere vertex generator
// Turns a ring and slice index pair into one vertex of a UV sphere.
// ----------------------------------------------------------------------------
// Usage: each beat on the req_ channel carries a ring and a slice index; the
// rsp_ channel returns one vertex beat for it, in order. Position, normal,
// tangent and texture coordinates travel in rsp_tdata and the index error
// flag in rsp_tuser.
// One beat is accepted every cycle while req_tready is high. A beat passes
// three front stages, one CORDIC cell per rotation step, five post stages
// and the output register.
// A stalled receiver is absorbed by a skid register at the output; the stall
// then backs up through the cell chain until req_tready drops.
// Reset loads radius 256 and 20 slices and stacks with their reciprocals.
// A write to the slice or stack count recomputes both reciprocals with a
// bit-serial divider; req_tready stays low after the write until both are done.
// The user must write configuration only while the block is empty; the block does not enforce it.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator_top #(
   parameter int CORDIC_STEPS = uvs_pkg::CordicSteps
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // ring_index, slice_index
   input  wire logic [23:0]  req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tangent_x,
   // tangent_y, tangent_z, tex_u, tex_v
   output logic [183:0]      rsp_tdata,
   // index_error
   output logic              rsp_tuser,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import uvs_pkg::*;

   // Configuration.
   logic [RadW-1:0]   radius_ff;
   logic [IdxW-1:0]   slices_ff, stacks_ff, eff_s, eff_t;
   logic [RecipW-1:0] recip_s, recip_t;
   logic              wr, start_ff, busy_s, busy_t, busy;
   logic [1:0]        reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[3:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RadiusReset;
         slices_ff <= CountReset;
         stacks_ff <= CountReset;
         start_ff  <= 1'b0;
      end else begin
         start_ff <= wr && (reg_sel == RegSlices || reg_sel == RegStacks);
         if (wr) begin
            case (reg_sel)
               RegRadius: radius_ff <= csr_pwdata[RadW-1:0];
               RegSlices: slices_ff <= csr_pwdata[IdxW-1:0];
               RegStacks: stacks_ff <= csr_pwdata[IdxW-1:0];
               default:   ;
            endcase
         end
      end
   end

   always_comb begin
      case (reg_sel)
         RegRadius: csr_prdata = 32'(radius_ff);
         RegSlices: csr_prdata = 32'(slices_ff);
         RegStacks: csr_prdata = 32'(stacks_ff);
         default:   csr_prdata = '0;
      endcase
   end

   always_comb begin
      if (int'(slices_ff) > MaxCount) begin
         eff_s = IdxW'(MaxCount);
      end else if (slices_ff == '0) begin
         eff_s = IdxW'(1);
      end else begin
         eff_s = slices_ff;
      end
      if (int'(stacks_ff) > MaxCount) begin
         eff_t = IdxW'(MaxCount);
      end else if (stacks_ff < IdxW'(2)) begin
         eff_t = IdxW'(2);
      end else begin
         eff_t = stacks_ff;
      end
   end

   uvs_recip_div u_div_s (
      .clock(clock), .reset(reset), .start(start_ff), .divisor(eff_s),
      .busy(busy_s), .quotient(recip_s)
   );

   uvs_recip_div u_div_t (
      .clock(clock), .reset(reset), .start(start_ff), .divisor(eff_t),
      .busy(busy_t), .quotient(recip_t)
   );

   assign busy = start_ff || busy_s || busy_t;

   // Front stages: index check, phase products, angle setup.
   logic [2:0]      fv_ff;
   logic [3:0]      frdy;
   logic [IdxW-1:0] ri_ff, si_ff, ri, si;
   side_type        s0_ff, s1_ff, s0_in, s2_in;
   logic [ProdW-1:0] tp_ff, pp_ff;
   logic [ProdW:0]  tu_sum, tv_sum;
   logic [31:0]     ph_p, ph_t;
   logic [60:0]     zp_p, zp_t;
   cordic_type      c0_in;

   logic       cv   [CORDIC_STEPS+1];
   logic       crdy [CORDIC_STEPS+1];
   cordic_type cd   [CORDIC_STEPS+1];
   side_type   cs   [CORDIC_STEPS+1];

   assign ri = req_tdata[IdxW-1:0];
   assign si = req_tdata[2*IdxW-1:IdxW];

   always_comb begin
      frdy[3] = crdy[0];
      for (int k = 2; k >= 0; k--) begin
         frdy[k] = !fv_ff[k] || frdy[k+1];
      end
      req_tready = frdy[0] && !busy;
   end

   always_comb begin
      s0_in          = '0;
      s0_in.err      = (ri > eff_t) || (si > eff_s);
      s0_in.pole_top = ri == '0;
      s0_in.pole_bot = ri == eff_t;

      ph_p   = pp_ff[32:1];
      ph_t   = tp_ff[31:0];
      zp_p   = 61'(ph_p[29:0]) * 61'(HalfPiQ30);
      zp_t   = 61'(ph_t[29:0]) * 61'(HalfPiQ30);
      tu_sum = {1'b0, tp_ff} + (ProdW+1)'(32768);
      tv_sum = {1'b0, pp_ff} + (ProdW+1)'(32768);

      s2_in        = s1_ff;
      s2_in.quad_p = ph_p[31:30];
      s2_in.quad_t = ph_t[31:30];
      s2_in.tex_u  = (tu_sum[ProdW:16] > (ProdW-15)'(TexOne)) ? TexOne
                                                              : tu_sum[16+TexW-1:16];
      s2_in.tex_v  = (tv_sum[ProdW:16] > (ProdW-15)'(TexOne)) ? TexOne
                                                              : tv_sum[16+TexW-1:16];

      c0_in.phi.x   = CordicGain;
      c0_in.phi.y   = '0;
      c0_in.phi.z   = signed'({1'b0, zp_p[60:30]});
      c0_in.theta.x = CordicGain;
      c0_in.theta.y = '0;
      c0_in.theta.z = signed'({1'b0, zp_t[60:30]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         if (frdy[0]) fv_ff[0] <= req_tvalid && req_tready;
         if (frdy[1]) fv_ff[1] <= fv_ff[0];
         if (frdy[2]) fv_ff[2] <= fv_ff[1];
      end
      if (frdy[0] && req_tvalid && req_tready) begin
         ri_ff <= ri;
         si_ff <= si;
         s0_ff <= s0_in;
      end
      if (frdy[1] && fv_ff[0]) begin
         tp_ff <= ProdW'(si_ff) * ProdW'(recip_s);
         pp_ff <= ProdW'(ri_ff) * ProdW'(recip_t);
         s1_ff <= s0_ff;
      end
      if (frdy[2] && fv_ff[1]) begin
         cd[0] <= c0_in;
         cs[0] <= s2_in;
      end
   end

   assign cv[0] = fv_ff[2];

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
      uvs_cordic_cell #(.Step(k)) u_cell (
         .clock(clock), .reset(reset),
         .up_valid(cv[k]), .up_ready(crdy[k]), .up_data(cd[k]), .up_side(cs[k]),
         .down_valid(cv[k+1]), .down_ready(crdy[k+1]),
         .down_data(cd[k+1]), .down_side(cs[k+1])
      );
   end

   // Post stages and output skid.
   logic    pv, skid_v_ff, out_v_ff, pop;
   res_type pd, skid_ff, out_ff;

   uvs_post u_post (
      .clock(clock), .reset(reset), .radius(radius_ff),
      .up_valid(cv[CORDIC_STEPS]), .up_ready(crdy[CORDIC_STEPS]),
      .up_data(cd[CORDIC_STEPS]), .up_side(cs[CORDIC_STEPS]),
      .down_valid(pv), .down_ready(!skid_v_ff), .down_data(pd)
   );

   assign pop = !out_v_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (pop) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= pv;
         end
      end else if (pv && !skid_v_ff) begin
         skid_v_ff <= 1'b1;
      end
      if (pop) begin
         out_ff <= skid_v_ff ? skid_ff : pd;
      end else if (pv && !skid_v_ff) begin
         skid_ff <= pd;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tuser  = out_ff.index_error;
   assign rsp_tdata  = {3'b000, out_ff.tex_v, out_ff.tex_u, out_ff.tangent_z,
                        out_ff.tangent_y, out_ff.tangent_x, out_ff.normal_z,
                        out_ff.normal_y, out_ff.normal_x, out_ff.pos_z,
                        out_ff.pos_y, out_ff.pos_x};

`ifndef SYNTH
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("index error beat carries nonzero data");

   a_tan_y_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[130:115] == '0)
      else $error("tangent y is nonzero");

   a_cfg_block: assert property (@(posedge clock) disable iff (reset)
      wr && (reg_sel == RegSlices || reg_sel == RegStacks) |=> !req_tready)
      else $error("input accepted while reciprocals are recomputed");
`endif

endmodule
`default_nettype wire
